/* rtl/mbrua_pkg.sv */
package mbrua_pkg;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int WORD_W    = 32;
  localparam int NUM_REGS  = 32;
  localparam int REG_W     = $clog2(NUM_REGS);
  localparam int OPN_W     = 2;
  localparam int CFG_IDX_W = 8;

  localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
  localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(4);
  localparam logic [REG_W-1:0]  LINK_REG  = REG_W'(NUM_REGS - 1);

  // Operation codes of an input beat
  localparam logic [OPN_W-1:0] OP_START   = 2'd0;
  localparam logic [OPN_W-1:0] OP_ANALYZE = 2'd1;
  localparam logic [OPN_W-1:0] OP_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_EN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOTING = 8'd1;

  // Command queue between decode and execute
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register-use decision for one instruction word
  typedef struct packed {
    logic             mark_rs;
    logic             mark_rt;
    logic             mark_rd;
    logic [REG_W-1:0] rs;
    logic [REG_W-1:0] rt;
    logic [REG_W-1:0] rd;
    logic             set_delay;
    logic             wipe;
  } dec_t;

  // One queued command
  typedef struct packed {
    logic [OPN_W-1:0]  opn;
    logic [ADDR_W-1:0] start_addr;
    logic              ferr;
    logic [REG_W-1:0]  ri;
    dec_t              dec;
  } cmd_t;

endpackage

/* rtl/mips_block_register_use_analyzer.sv */
// Register-use analyzer for one block of MIPS instructions.
// Input channel (in_valid / in_stall): each beat carries an operation code.
//   Start opens a block at in_start_address; analyze decodes in_instruction
//   and stamps the current address as the last use of every register it
//   names; read only reports. Every beat reports in_reg_index's entry.
// Result channel (out_valid / out_stall): exactly one beat per input beat,
//   in order: block end, next fetch address, abort and invalidate flags,
//   and the last-use address (all ones when the entry holds nothing).
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_wdata): index 0 is
//   the link-blocks enable, index 1 the booting flag; other indexes are
//   ignored. cfg_ready is always high; write only while the block is idle.
// Result path: an input beat is written into the command queue, then the
//   execute stage pops it and registers its result beat.
// Throughput: one beat per cycle while out_stall is low. A two-entry
//   command queue separates decode and execute.
// Reset: table reads all ones, no block is open, booting is set and
//   linking is off. When out_stall is held, the result beat holds, the
//   queue fills within two beats and in_stall rises.
module mips_block_register_use_analyzer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mbrua_pkg::OPN_W-1:0]      in_operation,
  input  logic [mbrua_pkg::WORD_W-1:0]     in_instruction,
  input  logic [mbrua_pkg::ADDR_W-1:0]     in_start_address,
  input  logic                             in_fetch_error,
  input  logic [mbrua_pkg::REG_W-1:0]      in_reg_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_block_end,
  output logic [mbrua_pkg::ADDR_W-1:0]     out_next_fetch_address,
  output logic                             out_aborted,
  output logic                             out_invalidated,
  output logic [mbrua_pkg::ADDR_W-1:0]     out_last_use,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbrua_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                             cfg_wdata
);

  logic            link_en_r, link_en_nxt;
  logic            booting_r, booting_nxt;
  logic            push, q_full, pop, q_valid;
  mbrua_pkg::cmd_t push_cmd, pop_cmd;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    link_en_nxt = link_en_r;
    booting_nxt = booting_r;
    if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == mbrua_pkg::CFG_LINK_EN) begin
        link_en_nxt = cfg_wdata;
      end else if (cfg_index == mbrua_pkg::CFG_BOOTING) begin
        booting_nxt = cfg_wdata;
      end else begin
        link_en_nxt = link_en_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_en_r <= 1'b0;
      booting_r <= 1'b1;
    end else begin
      link_en_r <= link_en_nxt;
      booting_r <= booting_nxt;
    end
  end

  mbrua_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_instruction   (in_instruction),
    .in_start_address (in_start_address),
    .in_fetch_error   (in_fetch_error),
    .in_reg_index     (in_reg_index),
    .link_mode        (link_en_r && !booting_r),
    .q_full           (q_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  mbrua_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  mbrua_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (q_valid),
    .cmd                    (pop_cmd),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_block_end          (out_block_end),
    .out_next_fetch_address (out_next_fetch_address),
    .out_aborted            (out_aborted),
    .out_invalidated        (out_invalidated),
    .out_last_use           (out_last_use)
  );

endmodule

/* rtl/mbrua_front.sv */
module mbrua_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbrua_pkg::OPN_W-1:0]   in_operation,
  input  logic [mbrua_pkg::WORD_W-1:0]  in_instruction,
  input  logic [mbrua_pkg::ADDR_W-1:0]  in_start_address,
  input  logic                          in_fetch_error,
  input  logic [mbrua_pkg::REG_W-1:0]   in_reg_index,
  input  logic                          link_mode,
  input  logic                          q_full,
  output logic                          push,
  output mbrua_pkg::cmd_t               push_cmd
);

  // Register-use classes
  localparam logic [3:0] CL_EMPTY  = 4'd0;
  localparam logic [3:0] CL_I      = 4'd1;
  localparam logic [3:0] CL_BR     = 4'd2;
  localparam logic [3:0] CL_J      = 4'd3;
  localparam logic [3:0] CL_R      = 4'd4;
  localparam logic [3:0] CL_B      = 4'd5;
  localparam logic [3:0] CL_SH     = 4'd6;
  localparam logic [3:0] CL_RT     = 4'd7;
  localparam logic [3:0] CL_CF     = 4'd8;
  localparam logic [3:0] CL_RS     = 4'd9;
  localparam logic [3:0] CL_RD     = 4'd10;
  localparam logic [3:0] CL_TODO   = 4'd11;
  localparam logic [3:0] CL_SPEC   = 4'd12;
  localparam logic [3:0] CL_REGIMM = 4'd13;
  localparam logic [3:0] CL_COP0   = 4'd14;
  localparam logic [3:0] CL_COP1   = 4'd15;

  // Primary opcodes that matter for the link exceptions
  localparam logic [5:0] OPC_REGIMM = 6'd1;
  localparam logic [5:0] OPC_JAL    = 6'd3;
  localparam logic [5:0] OPC_BEQ    = 6'd4;
  localparam logic [5:0] OPC_BNE    = 6'd5;
  localparam logic [5:0] OPC_BLEZ   = 6'd6;
  localparam logic [5:0] OPC_BGTZ   = 6'd7;
  localparam logic [5:0] OPC_COP1   = 6'd17;
  localparam logic [5:0] OPC_BEQL   = 6'd20;
  localparam logic [5:0] OPC_BNEL   = 6'd21;
  localparam logic [5:0] OPC_BLEZL  = 6'd22;
  localparam logic [5:0] OPC_BGTZL  = 6'd23;
  localparam logic [4:0] RS_BC      = 5'd8;

  function automatic logic [3:0] main_class(input logic [5:0] op);
    logic [3:0] c;
    unique case (op)
      6'd0:                                   c = CL_SPEC;
      6'd1:                                   c = CL_REGIMM;
      6'd2, 6'd3:                             c = CL_J;
      6'd4, 6'd5, 6'd20, 6'd21:               c = CL_B;
      6'd6, 6'd7, 6'd22, 6'd23:               c = CL_BR;
      6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
      6'd24, 6'd25, 6'd26, 6'd27,
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
      6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46,
      6'd48, 6'd52, 6'd55, 6'd56, 6'd60, 6'd63: c = CL_I;
      6'd15:                                  c = CL_RT;
      6'd16:                                  c = CL_COP0;
      6'd17:                                  c = CL_COP1;
      6'd18, 6'd47:                           c = CL_TODO;
      6'd49, 6'd53, 6'd57, 6'd61:             c = CL_RS;
      default:                                c = CL_EMPTY;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] spec_class(input logic [5:0] fn);
    logic [3:0] c;
    unique case (fn)
      6'd0, 6'd2, 6'd3, 6'd56, 6'd58, 6'd59, 6'd60, 6'd62, 6'd63: c = CL_SH;
      6'd4, 6'd6, 6'd7, 6'd20, 6'd22, 6'd23,
      6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
      6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47:                c = CL_R;
      6'd8, 6'd9:                                               c = CL_BR;
      6'd12, 6'd13, 6'd15, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52,
      6'd54:                                                    c = CL_TODO;
      6'd16, 6'd18:                                             c = CL_RD;
      6'd17, 6'd19:                                             c = CL_RS;
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31:  c = CL_I;
      default:                                                  c = CL_EMPTY;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] regimm_class(input logic [4:0] rt);
    logic [3:0] c;
    unique case (rt)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd18, 5'd19: c = CL_BR;
      5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14:             c = CL_TODO;
      default:                                             c = CL_EMPTY;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] cop0_class(input logic [4:0] rs, input logic [4:0] rt);
    logic [3:0] c;
    unique case (rs)
      5'd0, 5'd1, 5'd4, 5'd5: c = CL_RT;
      5'd2, 5'd6:             c = CL_TODO;
      5'd8:                   c = (rt < 5'd4) ? CL_TODO : CL_EMPTY;
      default:                c = CL_EMPTY;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] cop1_class(input logic [4:0] rs, input logic [4:0] rt);
    logic [3:0] c;
    unique case (rs)
      5'd0, 5'd1, 5'd4, 5'd5, 5'd6: c = CL_RT;
      5'd2:                         c = CL_CF;
      5'd8:                         c = (rt < 5'd4) ? CL_J : CL_EMPTY;
      default:                      c = CL_EMPTY;
    endcase
    return c;
  endfunction

  logic [5:0] op;
  logic [4:0] rs, rt, rd;
  logic [3:0] cls_main, cls;
  mbrua_pkg::dec_t dec;

  assign op = in_instruction[31:26];
  assign rs = in_instruction[25:21];
  assign rt = in_instruction[20:16];
  assign rd = in_instruction[15:11];

  // Resolve the subfield tables
  assign cls_main = main_class(op);
  always_comb begin
    unique case (cls_main)
      CL_SPEC:   cls = spec_class(in_instruction[5:0]);
      CL_REGIMM: cls = regimm_class(rt);
      CL_COP0:   cls = cop0_class(rs, rt);
      CL_COP1:   cls = cop1_class(rs, rt);
      default:   cls = cls_main;
    endcase
  end

  // Turn the class into register marks and block control
  always_comb begin
    dec = '0;
    dec.rs = rs;
    dec.rt = rt;
    dec.rd = rd;
    unique case (cls)
      CL_I: begin
        dec.mark_rt = 1'b1;
        dec.mark_rs = 1'b1;
      end
      CL_R: begin
        dec.mark_rt = 1'b1;
        dec.mark_rs = 1'b1;
        dec.mark_rd = 1'b1;
      end
      CL_SH: begin
        dec.mark_rd = 1'b1;
        dec.mark_rt = 1'b1;
      end
      CL_RT: dec.mark_rt = 1'b1;
      CL_RS: dec.mark_rs = 1'b1;
      CL_RD: dec.mark_rd = 1'b1;
      CL_CF: dec.mark_rt = (rd == 5'd0) || (rd == 5'd31);
      CL_BR: begin
        dec.mark_rs = 1'b1;
        dec.set_delay = !(link_mode && (op == OPC_BLEZ || op == OPC_BGTZ ||
                                        op == OPC_BLEZL || op == OPC_BGTZL)) &&
                        !(link_mode && op == OPC_REGIMM && rt < 5'd4);
      end
      CL_B: begin
        dec.mark_rt = 1'b1;
        dec.mark_rs = 1'b1;
        dec.set_delay = !(link_mode && (op == OPC_BEQ || op == OPC_BNE ||
                                        op == OPC_BEQL || op == OPC_BNEL));
      end
      CL_J: begin
        dec.set_delay = !(link_mode && op == OPC_COP1 && rs == RS_BC && rt < 5'd4) &&
                        (op != OPC_JAL);
      end
      CL_TODO: dec.wipe = 1'b1;
      default: ;
    endcase
  end

  // Accept a beat whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_cmd.opn        = in_operation;
    push_cmd.start_addr = in_start_address;
    push_cmd.ferr       = in_fetch_error;
    push_cmd.ri         = in_reg_index;
    push_cmd.dec        = dec;
  end

endmodule

/* rtl/mbrua_queue.sv */
module mbrua_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbrua_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output mbrua_pkg::cmd_t pop_cmd
);

  mbrua_pkg::cmd_t                  slot_r [mbrua_pkg::Q_DEPTH];
  logic [mbrua_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mbrua_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mbrua_pkg::Q_CNT_W-1:0]    count_r, count_nxt;

  localparam logic [mbrua_pkg::Q_PTR_W-1:0] LAST_PTR = mbrua_pkg::Q_PTR_W'(mbrua_pkg::Q_DEPTH - 1);
  localparam logic [mbrua_pkg::Q_CNT_W-1:0] FULL_CNT = mbrua_pkg::Q_CNT_W'(mbrua_pkg::Q_DEPTH);
  localparam logic [mbrua_pkg::Q_CNT_W-1:0] ONE_CNT  = mbrua_pkg::Q_CNT_W'(1);

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + ONE_CNT;
    end else if (pop && !push) begin
      count_nxt = count_r - ONE_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + ONE_CNT))
    else $error("queue count did not advance on push");

endmodule

/* rtl/mbrua_back.sv */
module mbrua_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mbrua_pkg::cmd_t               cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_block_end,
  output logic [mbrua_pkg::ADDR_W-1:0]  out_next_fetch_address,
  output logic                          out_aborted,
  output logic                          out_invalidated,
  output logic [mbrua_pkg::ADDR_W-1:0]  out_last_use
);

  // Last-use table: data without reset, valid bits cleared all together
  logic [mbrua_pkg::ADDR_W-1:0]   tbl_r   [mbrua_pkg::NUM_REGS];
  logic [mbrua_pkg::ADDR_W-1:0]   tbl_nxt [mbrua_pkg::NUM_REGS];
  logic [mbrua_pkg::NUM_REGS-1:0] vld_r, vld_nxt, hit;

  logic [mbrua_pkg::ADDR_W-1:0] cur_r, cur_nxt;
  logic [mbrua_pkg::ADDR_W-1:0] start_r, start_nxt;
  logic                         delay_r, delay_nxt;
  logic                         done_r, done_nxt;

  logic                         out_valid_r;
  logic                         end_r, end_nxt;
  logic [mbrua_pkg::ADDR_W-1:0] nfa_r;
  logic                         abrt_r, abrt_nxt;
  logic                         inval_r, inval_nxt;
  logic [mbrua_pkg::ADDR_W-1:0] lu_r, lu_nxt;

  logic slot, delay_a, delay_b, finish, wipe;

  // Take a command when the result register is free or being drained
  assign pop = q_valid && (!out_valid_r || !out_stall);

  // Registers named by this instruction
  always_comb begin
    for (int i = 0; i < mbrua_pkg::NUM_REGS; i++) begin
      hit[i] = (cmd.dec.mark_rs && cmd.dec.rs == mbrua_pkg::REG_W'(i)) ||
               (cmd.dec.mark_rt && cmd.dec.rt == mbrua_pkg::REG_W'(i)) ||
               (cmd.dec.mark_rd && cmd.dec.rd == mbrua_pkg::REG_W'(i));
    end
  end

  // Execute one command against the block state
  always_comb begin
    cur_nxt   = cur_r;
    start_nxt = start_r;
    delay_nxt = delay_r;
    done_nxt  = done_r;
    end_nxt   = 1'b0;
    abrt_nxt  = 1'b0;
    inval_nxt = 1'b0;
    finish    = 1'b0;
    wipe      = 1'b0;
    slot      = delay_r && (cur_r != start_r);
    delay_a   = slot ? 1'b0 : delay_r;
    delay_b   = delay_a || cmd.dec.set_delay;
    tbl_nxt   = tbl_r;
    vld_nxt   = vld_r;

    unique case (cmd.opn)
      mbrua_pkg::OP_START: begin
        start_nxt = cmd.start_addr;
        cur_nxt   = cmd.start_addr;
        done_nxt  = cmd.ferr;
        end_nxt   = cmd.ferr;
        abrt_nxt  = cmd.ferr;
      end
      mbrua_pkg::OP_ANALYZE: begin
        if (done_r) begin
          end_nxt = 1'b1;
        end else if (cmd.ferr) begin
          delay_nxt = delay_a;
          wipe      = 1'b1;
          finish    = 1'b1;
          abrt_nxt  = 1'b1;
        end else begin
          delay_nxt = delay_b;
          inval_nxt = cmd.dec.wipe;
          wipe      = cmd.dec.wipe;
          for (int i = 0; i < mbrua_pkg::NUM_REGS; i++) begin
            if (hit[i]) begin
              tbl_nxt[i] = cur_r;
              vld_nxt[i] = 1'b1;
            end
          end
          if (slot) begin
            finish = 1'b1;
          end else begin
            cur_nxt = cur_r + mbrua_pkg::ADDR_STEP;
            finish  = !delay_b && cmd.dec.wipe;
          end
        end
      end
      default: end_nxt = done_r;
    endcase

    // Drop the whole table on a wipe, and close the block when it finishes
    if (wipe) begin
      vld_nxt = '0;
    end
    if (finish) begin
      vld_nxt[mbrua_pkg::LINK_REG] = 1'b0;
      cur_nxt  = start_r;
      done_nxt = 1'b1;
      end_nxt  = 1'b1;
    end

    lu_nxt = vld_nxt[cmd.ri] ? tbl_nxt[cmd.ri] : mbrua_pkg::ALL_ONES;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cur_r       <= '0;
      start_r     <= '0;
      delay_r     <= 1'b0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        vld_r   <= vld_nxt;
        cur_r   <= cur_nxt;
        start_r <= start_nxt;
        delay_r <= delay_nxt;
        done_r  <= done_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Table data and result beat
  always_ff @(posedge clk) begin
    if (pop) begin
      tbl_r   <= tbl_nxt;
      end_r   <= end_nxt;
      nfa_r   <= cur_nxt;
      abrt_r  <= abrt_nxt;
      inval_r <= inval_nxt;
      lu_r    <= lu_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_block_end          = end_r;
  assign out_next_fetch_address = nfa_r;
  assign out_aborted            = abrt_r;
  assign out_invalidated        = inval_r;
  assign out_last_use           = lu_r;

  a_done_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cur_r == start_r))
    else $error("closed block left fetch address away from block start");

  a_abort_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && abrt_r) |-> end_r)
    else $error("aborted beat without block end");

  a_abort_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(abrt_r && inval_r))
    else $error("beat both aborted and invalidated");

  a_close_link: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && finish) |=> !vld_r[mbrua_pkg::LINK_REG])
    else $error("link register entry still valid after block end");

endmodule

/* tb/sv/mbrua_tb_pkg.sv */
package mbrua_tb_pkg;

  import mbrua_pkg::*;

  // Register-use classes after the opcode and subfield decode
  typedef enum logic [3:0] {
    USE_NONE,
    USE_RS_RT,
    USE_REG3,
    USE_SHIFT,
    USE_RT,
    USE_RS,
    USE_RD,
    USE_CTC,
    USE_BRANCH1,
    USE_BRANCH2,
    USE_JUMP,
    USE_WIPE
  } use_e;

  // MIPS primary opcodes, function codes and the BC rs field that the checker or the stimulus names
  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_REGIMM  = 6'd1;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;
  localparam logic [5:0] OPC_BEQ     = 6'd4;
  localparam logic [5:0] OPC_BNE     = 6'd5;
  localparam logic [5:0] OPC_BLEZ    = 6'd6;
  localparam logic [5:0] OPC_BGTZ    = 6'd7;
  localparam logic [5:0] OPC_ADDIU   = 6'd9;
  localparam logic [5:0] OPC_LUI     = 6'd15;
  localparam logic [5:0] OPC_COP0    = 6'd16;
  localparam logic [5:0] OPC_COP1    = 6'd17;
  localparam logic [5:0] OPC_COP2    = 6'd18;
  localparam logic [5:0] OPC_BEQL    = 6'd20;
  localparam logic [5:0] OPC_BNEL    = 6'd21;
  localparam logic [5:0] OPC_BLEZL   = 6'd22;
  localparam logic [5:0] OPC_BGTZL   = 6'd23;
  localparam logic [5:0] OPC_SW      = 6'd43;
  localparam logic [5:0] FN_ADD      = 6'd32;
  localparam logic [5:0] FN_ADDU     = 6'd33;
  localparam logic [4:0] COP_RS_BC   = 5'd8;

  // One result beat
  typedef struct packed {
    logic              block_end;
    logic [ADDR_W-1:0] next_addr;
    logic              aborted;
    logic              invalidated;
    logic [ADDR_W-1:0] last_use;
  } analysis_t;

  class last_use_predictor;
    logic [ADDR_W-1:0] last_use [NUM_REGS];
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] blk_start;
    bit                delay_pend;
    bit                blk_done;
    bit                link_en;
    bit                booting;
    analysis_t         expected_analyses [$];
    int unsigned       mismatches;

    function new();
      clear_table();
      cur_addr   = '0;
      blk_start  = '0;
      delay_pend = 1'b0;
      blk_done   = 1'b1;
      link_en    = 1'b0;
      booting    = 1'b1;
      mismatches = 0;
    endfunction

    function void clear_table();
      foreach (last_use[k]) last_use[k] = ALL_ONES;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      if (idx == CFG_LINK_EN) begin
        link_en = val;
      end else if (idx == CFG_BOOTING) begin
        booting = val;
      end
    endfunction

    function use_e special_use(logic [5:0] fn);
      case (fn) inside
        0, 2, 3, 56, 58, 59, 60, 62, 63:               return USE_SHIFT;
        4, 6, 7, 20, 22, 23, [32:39], [42:47]:         return USE_REG3;
        8, 9:                                          return USE_BRANCH1;
        12, 13, 15, [48:52], 54:                       return USE_WIPE;
        16, 18:                                        return USE_RD;
        17, 19:                                        return USE_RS;
        [24:31]:                                       return USE_RS_RT;
        default:                                       return USE_NONE;
      endcase
    endfunction

    function use_e classify(logic [WORD_W-1:0] w);
      logic [5:0] op;
      logic [4:0] rs;
      logic [4:0] rt;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      case (op) inside
        OPC_SPECIAL: return special_use(w[5:0]);
        OPC_REGIMM: begin
          if (rt inside {[0:3], [16:19]}) return USE_BRANCH1;
          if (rt inside {[8:12], 14}) return USE_WIPE;
          return USE_NONE;
        end
        OPC_J, OPC_JAL:                        return USE_JUMP;
        OPC_BEQ, OPC_BNE, OPC_BEQL, OPC_BNEL:  return USE_BRANCH2;
        OPC_BLEZ, OPC_BGTZ, OPC_BLEZL, OPC_BGTZL: return USE_BRANCH1;
        OPC_LUI:                               return USE_RT;
        OPC_COP0: begin
          if (rs inside {0, 1, 4, 5}) return USE_RT;
          if (rs inside {2, 6}) return USE_WIPE;
          if (rs == COP_RS_BC && rt < 4) return USE_WIPE;
          return USE_NONE;
        end
        OPC_COP1: begin
          if (rs inside {0, 1, 4, 5, 6}) return USE_RT;
          if (rs == 2) return USE_CTC;
          if (rs == COP_RS_BC && rt < 4) return USE_JUMP;
          return USE_NONE;
        end
        OPC_COP2, 47:                          return USE_WIPE;
        19, [28:31], 50, 51, 54, 58, 59, 62:   return USE_NONE;
        49, 53, 57, 61:                        return USE_RS;
        default:                               return USE_RS_RT;
      endcase
    endfunction

    function void stamp(logic [REG_W-1:0] r);
      last_use[r] = cur_addr;
    endfunction

    function void close_block();
      last_use[LINK_REG] = ALL_ONES;
      cur_addr = blk_start;
      blk_done = 1'b1;
    endfunction

    // Stamp the registers a word uses; return 1 when it wipes the table
    function bit decode_word(logic [WORD_W-1:0] w);
      logic [5:0] op;
      logic [4:0] rs;
      logic [4:0] rt;
      logic [4:0] rd;
      bit         lk;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      lk = link_en && !booting;
      case (classify(w))
        USE_RS_RT: begin
          stamp(rt);
          stamp(rs);
        end
        USE_REG3: begin
          stamp(rt);
          stamp(rs);
          stamp(rd);
        end
        USE_SHIFT: begin
          stamp(rd);
          stamp(rt);
        end
        USE_RT: stamp(rt);
        USE_RS: stamp(rs);
        USE_RD: stamp(rd);
        USE_CTC: begin
          if (rd == 5'd0 || rd == 5'd31) stamp(rt);
        end
        USE_BRANCH1: begin
          stamp(rs);
          if (!(lk && (op inside {OPC_BLEZ, OPC_BGTZ, OPC_BLEZL, OPC_BGTZL} ||
                       (op == OPC_REGIMM && rt < 4))))
            delay_pend = 1'b1;
        end
        USE_BRANCH2: begin
          stamp(rt);
          stamp(rs);
          if (!lk) delay_pend = 1'b1;
        end
        USE_JUMP: begin
          if (!(lk && op == OPC_COP1) && op != OPC_JAL) delay_pend = 1'b1;
        end
        USE_WIPE: begin
          clear_table();
          return 1'b1;
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    // Advance the model by one accepted input beat and queue its result
    function void predict_beat(logic [OPN_W-1:0] opn, logic [WORD_W-1:0] word,
                               logic [ADDR_W-1:0] start, logic ferr,
                               logic [REG_W-1:0] ri);
      analysis_t e;
      bit        slot;
      e = '0;
      if (opn == OP_START) begin
        blk_start   = start;
        cur_addr    = start;
        blk_done    = ferr;
        e.block_end = ferr;
        e.aborted   = ferr;
      end else if (opn == OP_ANALYZE) begin
        if (blk_done) begin
          e.block_end = 1'b1;
        end else begin
          slot = delay_pend && (cur_addr != blk_start);
          if (slot) delay_pend = 1'b0;
          if (ferr) begin
            clear_table();
            close_block();
            e.block_end = 1'b1;
            e.aborted   = 1'b1;
          end else begin
            e.invalidated = decode_word(word);
            if (slot) begin
              close_block();
              e.block_end = 1'b1;
            end else begin
              cur_addr += ADDR_STEP;
              if (!delay_pend && e.invalidated) begin
                close_block();
                e.block_end = 1'b1;
              end
            end
          end
        end
      end else begin
        e.block_end = blk_done;
      end
      e.next_addr = cur_addr;
      e.last_use  = last_use[ri];
      expected_analyses.push_back(e);
    endfunction

    task report(string what, logic [31:0] want, logic [31:0] got);
      $display("mismatch %0d on %s: expected %h, got %h", mismatches, what, want, got);
      mismatches++;
    endtask

    // Compare one result beat with the oldest expectation
    task check_beat(analysis_t got);
      analysis_t e;
      if (expected_analyses.size() == 0) begin
        report("result beat with nothing expected", '0, got.next_addr);
      end else begin
        e = expected_analyses.pop_front();
        if (got.block_end !== e.block_end)
          report("block_end", 32'(e.block_end), 32'(got.block_end));
        if (got.next_addr !== e.next_addr)
          report("next_fetch_address", e.next_addr, got.next_addr);
        if (got.aborted !== e.aborted)
          report("aborted", 32'(e.aborted), 32'(got.aborted));
        if (got.invalidated !== e.invalidated)
          report("invalidated", 32'(e.invalidated), 32'(got.invalidated));
        if (got.last_use !== e.last_use)
          report("last_use", e.last_use, got.last_use);
      end
    endtask

    function int unsigned outstanding();
      return expected_analyses.size();
    endfunction
  endclass

endpackage

/* tb/sv/mips_block_register_use_analyzer_tb.sv */
module mips_block_register_use_analyzer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrua_pkg::*;
  import mbrua_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam logic [OPN_W-1:0]     OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
  localparam logic [5:0] BRANCH_OPS [10] = '{OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_BLEZ,
                                             OPC_BGTZ, OPC_BEQL, OPC_BNEL, OPC_BLEZL,
                                             OPC_BGTZL};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OPN_W-1:0]     in_operation;
  logic [WORD_W-1:0]    in_instruction;
  logic [ADDR_W-1:0]    in_start_address;
  logic                 in_fetch_error;
  logic [REG_W-1:0]     in_reg_index;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_block_end;
  logic [ADDR_W-1:0]    out_next_fetch_address;
  logic                 out_aborted;
  logic                 out_invalidated;
  logic [ADDR_W-1:0]    out_last_use;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_wdata;

  last_use_predictor tracker = new();
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       cycles = 0;

  mips_block_register_use_analyzer dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_instruction         (in_instruction),
    .in_start_address       (in_start_address),
    .in_fetch_error         (in_fetch_error),
    .in_reg_index           (in_reg_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_block_end          (out_block_end),
    .out_next_fetch_address (out_next_fetch_address),
    .out_aborted            (out_aborted),
    .out_invalidated        (out_invalidated),
    .out_last_use           (out_last_use),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Throttle the result side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Predict on each accepted input beat, then check each accepted result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.predict_beat(in_operation, in_instruction, in_start_address,
                             in_fetch_error, in_reg_index);
      if (out_valid && !out_stall)
        tracker.check_beat({out_block_end, out_next_fetch_address, out_aborted,
                            out_invalidated, out_last_use});
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mips_block_register_use_analyzer_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] enc(logic [5:0] op, logic [4:0] rs,
                                            logic [4:0] rt, logic [15:0] low);
    return {op, rs, rt, low};
  endfunction

  // Bias words toward the decode classes, with a share of raw noise
  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    int unsigned       pick;
    w    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 10) return w;
    if (pick < 25) begin
      w[31:26] = OPC_SPECIAL;
    end else if (pick < 32) begin
      w[31:26] = OPC_REGIMM;
    end else if (pick < 42) begin
      w[31:26] = $urandom_range(0, 1) ? OPC_COP1 : OPC_COP0;
      w[25:21] = 5'($urandom_range(0, 9));
      w[20:16] = 5'($urandom_range(0, 5));
      if ($urandom_range(0, 1)) w[15:11] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
    end else if (pick < 55) begin
      w[31:26] = BRANCH_OPS[$urandom_range(0, 9)];
    end else begin
      do begin
        w        = $urandom;
        w[31:26] = 6'($urandom_range(8, 63));
      end while (!(tracker.classify(w) inside {USE_RS_RT, USE_RT, USE_RS}));
    end
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] random_start();
    logic [ADDR_W-1:0] a;
    int unsigned       pick;
    a    = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6) a[1:0] = 2'b00;
    else if (pick < 8) a[ADDR_W-1:5] = '1;
    return a;
  endfunction

  // Offer one input beat and hold it until taken; entered and left at a falling edge
  task automatic send_beat(logic [OPN_W-1:0] opn, logic [WORD_W-1:0] word,
                           logic [ADDR_W-1:0] start, logic ferr, logic [REG_W-1:0] ri);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= opn;
    in_instruction   <= word;
    in_start_address <= start;
    in_fetch_error   <= ferr;
    in_reg_index     <= ri;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result is back
  task automatic idle_until_drained();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed blocks with random words; some broken blocks and noise
  task automatic run_phase(bit link, bit boot, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned count);
    int unsigned issued;
    int unsigned pick;
    bit          drained;
    idle_until_drained();
    write_reg(CFG_LINK_EN, link);
    write_reg(CFG_BOOTING, boot);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    issued  = 0;
    drained = 1'b0;
    while (issued < count) begin
      if (!drained && issued == count / 2) begin
        idle_until_drained();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (tracker.blk_done) begin
        if (pick < 4) begin
          // ignored: no block open
          send_beat(OP_ANALYZE, random_word(), $urandom, 1'($urandom_range(0, 1)),
                    5'($urandom_range(0, 31)));
        end else if (pick < 12) begin
          send_beat($urandom_range(0, 3) == 0 ? OP_SPARE : OP_READ, $urandom, $urandom,
                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
          issued++;
        end else begin
          send_beat(OP_START, $urandom, random_start(), $urandom_range(0, 19) == 0,
                    5'($urandom_range(0, 31)));
          issued++;
        end
      end else begin
        if (pick < 3) begin
          send_beat(OP_START, $urandom, random_start(), $urandom_range(0, 19) == 0,
                    5'($urandom_range(0, 31)));
        end else if (pick < 9) begin
          send_beat($urandom_range(0, 3) == 0 ? OP_SPARE : OP_READ, $urandom, $urandom,
                    1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        end else begin
          send_beat(OP_ANALYZE, random_word(), $urandom, $urandom_range(0, 39) == 0,
                    5'($urandom_range(0, 31)));
        end
        issued++;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_operation     = OP_READ;
    in_instruction   = '0;
    in_start_address = '0;
    in_fetch_error   = 1'b0;
    in_reg_index     = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_LINK_EN;
    cfg_wdata        = 1'b0;
    send_idle_pct    = 20;
    recv_idle_pct    = 76;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_SPARE, 1'b1);
    write_reg(CFG_LINK_EN, 1'b0);
    write_reg(CFG_BOOTING, 1'b1);

    // Reset contents, analyze with no block open, the spare operation
    send_beat(OP_READ, '0, '0, 1'b0, 5'd0);
    send_beat(OP_ANALYZE, enc(OPC_ADDIU, 5'd1, 5'd2, 16'h0001), '0, 1'b0, 5'd2);
    send_beat(OP_SPARE, '1, '1, 1'b1, 5'd31);
    // Fetch error on start, then an analyze that must be ignored
    send_beat(OP_START, '0, 32'h0000_1234, 1'b1, 5'd0);
    send_beat(OP_ANALYZE, '1, '0, 1'b0, 5'd31);
    // Block at the top of the address space; extreme register fields
    send_beat(OP_START, '0, 32'hFFFF_FFF8, 1'b0, 5'd0);
    send_beat(OP_ANALYZE, enc(OPC_SPECIAL, 5'd31, 5'd0, {5'd31, 5'd0, FN_ADD}), '0,
              1'b0, 5'd31);
    send_beat(OP_ANALYZE, enc(OPC_SW, 5'd0, 5'd31, 16'hFFFF), '0, 1'b0, 5'd0);
    send_beat(OP_ANALYZE, enc(OPC_COP1, 5'd2, 5'd5, {5'd31, 11'd0}), '0, 1'b0, 5'd5);
    send_beat(OP_ANALYZE, enc(OPC_COP1, 5'd2, 5'd6, {5'd7, 11'd0}), '0, 1'b0, 5'd6);
    // Branch, then a branch in its delay slot that carries into the next block
    send_beat(OP_ANALYZE, enc(OPC_BEQ, 5'd1, 5'd2, 16'h0010), '0, 1'b0, 5'd1);
    send_beat(OP_ANALYZE, enc(OPC_BNE, 5'd3, 5'd4, 16'hFFFC), '0, 1'b0, 5'd31);
    // Unsupported word with a branch pending: the block runs on to its slot
    send_beat(OP_START, '0, 32'h0000_0100, 1'b0, 5'd3);
    send_beat(OP_ANALYZE, enc(OPC_COP2, 5'd0, 5'd0, 16'h0000), '0, 1'b0, 5'd3);
    send_beat(OP_ANALYZE, enc(OPC_SPECIAL, 5'd5, 5'd6, {5'd7, 5'd0, FN_ADDU}), '0,
              1'b0, 5'd7);
    // Fetch error inside a block
    send_beat(OP_START, '0, 32'h0000_0200, 1'b0, 5'd0);
    send_beat(OP_ANALYZE, enc(OPC_ADDIU, 5'd8, 5'd9, 16'h8000), '0, 1'b0, 5'd9);
    send_beat(OP_ANALYZE, $urandom, '0, 1'b1, 5'd9);
    // jal does not end the block, j does; fetch error in the slot
    send_beat(OP_START, '0, 32'h0000_0300, 1'b0, 5'd0);
    send_beat(OP_ANALYZE, {OPC_JAL, 26'h3FF_FFFF}, '0, 1'b0, 5'd31);
    send_beat(OP_ANALYZE, {OPC_J, 26'h000_0000}, '0, 1'b0, 5'd31);
    send_beat(OP_ANALYZE, '0, '0, 1'b1, 5'd0);
    // Unsupported word with nothing pending ends the block
    send_beat(OP_START, '0, 32'h0000_0400, 1'b0, 5'd0);
    send_beat(OP_ANALYZE, enc(OPC_COP0, COP_RS_BC, 5'd0, 16'h0000), '0, 1'b0, 5'd0);
    send_beat(OP_READ, '1, '1, 1'b0, 5'd5);

    run_phase(1'b1, 1'b0, 20, 76, PHASE_ITEMS);
    run_phase(1'b1, 1'b1, 20, 76, PHASE_ITEMS);
    run_phase(1'b0, 1'b0, 76, 20, PHASE_ITEMS);
    run_phase(1'b1, 1'b0, 76, 20, PHASE_ITEMS);
    run_phase(1'b0, 1'b1, 0, 0, PHASE_ITEMS);
    run_phase(1'b1, 1'b0, 0, 0, PHASE_ITEMS);
    idle_until_drained();

    if (tracker.mismatches == 0) begin
      $display("mips_block_register_use_analyzer_tb: PASS");
    end else begin
      $display("mips_block_register_use_analyzer_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mbrua_pkg.sv
rtl/mbrua_front.sv
rtl/mbrua_queue.sv
rtl/mbrua_back.sv
rtl/mips_block_register_use_analyzer.sv
tb/sv/mbrua_tb_pkg.sv
tb/sv/mips_block_register_use_analyzer_tb.sv
